// ===== design/mocm_pkg.sv =====
// ----------------------------------------------------------------------------
// mocm_pkg: motor output channel mapper shared definitions
// Field widths, operation codes, register indexes, kind codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mocm_pkg;

  localparam int MOCM_CHANNELS = 8;

  localparam int OP_W    = 3;
  localparam int CH_W    = 3;
  localparam int VAL_W   = 16;
  localparam int DK_W    = 2;
  localparam int LVL_W   = 11;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 24;
  localparam int KIND_W  = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 3'd1;
  localparam logic [OP_W-1:0] OP_DISARM = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_KINDS   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_ENABLE  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_INVERT  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_THRESH  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ARM_REQ = 3'd4;

  localparam logic [7:0] THRESH_RESET = 8'd10;

  // channel kinds
  localparam logic [KIND_W-1:0] KIND_OFF   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOTOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SERVO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ESC   = 3'd4;

  // drive kinds of a result
  localparam logic [DK_W-1:0] DK_READ  = 2'd0;
  localparam logic [DK_W-1:0] DK_DUTY  = 2'd1;
  localparam logic [DK_W-1:0] DK_ANGLE = 2'd2;
  localparam logic [DK_W-1:0] DK_PULSE = 2'd3;

  // scaling constants
  localparam logic [LVL_W-1:0] DUTY_MAX   = 11'd255;
  localparam logic [LVL_W-1:0] ANGLE_MAX  = 11'd180;
  localparam logic [LVL_W-1:0] ANGLE_STOP = 11'd90;
  localparam logic [LVL_W-1:0] PULSE_MIN  = 11'd1000;
  localparam logic [LVL_W-1:0] PULSE_SPAN = 11'd1000;
  localparam logic [15:0]      MAG_SAT    = 16'd1004; // |v| from here gives duty 255
  localparam logic [15:0]      DUTY_MUL   = 16'd51;   // 255/1000 = 51/200
  localparam logic [15:0]      ANGLE_MUL  = 16'd9;    // 180/2000 = 9/100
  localparam logic [13:0]      RECIP25    = 14'd10486; // ceil(2^18/25)
  localparam int               RECIP_SH   = 18;

  typedef enum logic [1:0] {
    EM_APPLY = 2'd0,
    EM_STOP  = 2'd1,
    EM_READ  = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      in_accept;
    logic      mul_load;
    logic      div_load;
    logic      emit;
    emit_sel_t emit_sel;
    logic      scan_next;
  } mocm_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] opcode;
    logic            set_applies;
    logic            slot_free;
    logic            scan_hit;
    logic            scan_final;
  } mocm_stat_t;

  function automatic logic [KIND_W-1:0] chan_kind(logic [CDATA_W-1:0] kinds,
                                                   logic [CH_W-1:0] ch);
    logic [KIND_W-1:0] k;
    k = kinds[3*ch +: KIND_W];
    return (k > KIND_ESC) ? KIND_OFF : k;
  endfunction

endpackage

// ===== design/mocm_in_if.sv =====
// ----------------------------------------------------------------------------
// mocm_in_if: command channel
// One beat carries an opcode, a channel and a signed command value.
// ----------------------------------------------------------------------------
interface mocm_in_if
  import mocm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [CH_W-1:0]         channel;
  logic signed [VAL_W-1:0] command_value;

  modport source (output valid, opcode, channel, command_value, input ready);
  modport sink   (input valid, opcode, channel, command_value, output ready);
endinterface

// ===== design/mocm_out_if.sv =====
// ----------------------------------------------------------------------------
// mocm_out_if: result channel
// One beat carries the drive level of one channel or a readback value.
// ----------------------------------------------------------------------------
interface mocm_out_if
  import mocm_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic [DK_W-1:0]         drive_kind;
  logic [LVL_W-1:0]        drive_level;
  logic                    dir_forward;
  logic                    dir_reverse;
  logic signed [VAL_W-1:0] stored_value;
  logic                    last;

  modport source (output valid, out_channel, drive_kind, drive_level, dir_forward,
                  dir_reverse, stored_value, last, input ready);
  modport sink   (input valid, out_channel, drive_kind, drive_level, dir_forward,
                  dir_reverse, stored_value, last, output ready);
endinterface

// ===== design/mocm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mocm_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface mocm_cfg_if
  import mocm_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mocm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mocm_ctrl: sequencing controller
// Accepts one command beat, steps the scaling stages or the stop walk and
// hands results to the output register.
// ----------------------------------------------------------------------------
module mocm_ctrl
  import mocm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mocm_stat_t stat,
  output mocm_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMIT = 5'b01000,
    S_SCAN = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  emit_sel_t sel_r, sel_nxt;

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.emit_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.in_accept = 1'b1;
          case (stat.opcode) inside
            OP_SET: begin
              sel_nxt = EM_APPLY;
              if (stat.set_applies) state_nxt = S_MUL;
            end
            OP_DISARM, OP_STOP: begin
              sel_nxt   = EM_STOP;
              state_nxt = S_SCAN;
            end
            OP_READ: begin
              sel_nxt   = EM_READ;
              state_nxt = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // skipped channels never wait, hits wait for the slot
        if (!stat.scan_hit || stat.slot_free) begin
          cmd.emit      = stat.scan_hit;
          cmd.scan_next = 1'b1;
          if (stat.scan_final) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= EM_APPLY;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ===== design/mocm_dp.sv =====
// ----------------------------------------------------------------------------
// mocm_dp: mapper datapath
// Configuration registers, command store, armed flag, the two scaling
// stages shared by duty and angle, and the output register.
// ----------------------------------------------------------------------------
module mocm_dp
  import mocm_pkg::*;
#(
  parameter int CHANNELS = MOCM_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  mocm_in_if.sink    in_ch,
  mocm_out_if.source out_ch,
  mocm_cfg_if.sink   cfg_ch,
  input  mocm_cmd_t  cmd,
  output mocm_stat_t stat
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  // configuration
  logic [CDATA_W-1:0] kinds_r;
  logic [7:0]         enable_r, invert_r, thresh_r;
  logic               arm_req_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r   <= '0;
      enable_r  <= '0;
      invert_r  <= '0;
      thresh_r  <= THRESH_RESET;
      arm_req_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_KINDS:   kinds_r   <= cfg_ch.data;
        CFG_ENABLE:  enable_r  <= cfg_ch.data[7:0];
        CFG_INVERT:  invert_r  <= cfg_ch.data[7:0];
        CFG_THRESH:  thresh_r  <= cfg_ch.data[7:0];
        CFG_ARM_REQ: arm_req_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // stop walk qualification: enabled and of a driving kind
  logic [CHANNELS-1:0] qual;
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      qual[i] = enable_r[i] && (chan_kind(kinds_r, CH_W'(i)) != KIND_OFF);
    end
  end

  // command acceptance
  logic                    armed_r;
  logic signed [VAL_W-1:0] store_r [CHANNELS];
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] v_r;
  logic                    in_ch_ok, in_store;

  assign in_ch.ready = cmd.in_ready;
  assign in_ch_ok    = (32'(in_ch.channel) < CHANNELS);
  assign in_store    = in_ch_ok && enable_r[in_ch.channel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) store_r[i] <= '0;
    end else if (cmd.in_accept) begin
      case (in_ch.opcode) inside
        OP_SET: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (in_store && in_ch.channel == CH_W'(i)) store_r[i] <= in_ch.command_value;
          end
        end
        OP_ARM: armed_r <= 1'b1;
        OP_DISARM, OP_STOP: begin
          if (in_ch.opcode == OP_DISARM) armed_r <= 1'b0;
          for (int i = 0; i < CHANNELS; i++) store_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_accept) begin
      v_r  <= in_ch.command_value;
      ch_r <= (in_ch.opcode == OP_SET || in_ch.opcode == OP_READ) ? in_ch.channel : '0;
    end else if (cmd.scan_next) begin
      ch_r <= ch_r + CH_W'(1);
    end
  end

  logic [KIND_W-1:0] kind;
  assign kind = chan_kind(kinds_r, ch_r);

  // stage 1: inversion, magnitude, constant multiply
  logic signed [VAL_W-1:0] vi, vi_r;
  logic [15:0]             mag, p1, p1_r;
  logic [LVL_W-1:0]        w;
  logic                    servo;
  logic                    duty_sat_r, ang_lo_r, ang_hi_r;

  assign servo = (kind == KIND_SERVO);

  always_comb begin
    if (invert_r[ch_r]) vi = (v_r == 16'sh8000) ? 16'sh7fff : -v_r;
    else                vi = v_r;
    mag = vi[15] ? (~vi + 16'd1) : vi;
    w   = LVL_W'(vi + 16'sd1000);
    p1  = servo ? (16'(w) * ANGLE_MUL) : (16'(mag[9:0]) * DUTY_MUL);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      vi_r       <= vi;
      p1_r       <= p1;
      duty_sat_r <= (mag >= MAG_SAT);
      ang_lo_r   <= (vi <= -16'sd1000);
      ang_hi_r   <= (vi >= 16'sd1000);
    end
  end

  // stage 2: divide by 25 through a reciprocal (the /8 or /4 is a shift)
  logic [12:0] y;
  logic [26:0] qprod;
  logic [7:0]  q_r;

  assign y     = servo ? 13'(p1_r >> 2) : 13'(p1_r >> 3);
  assign qprod = 27'(y) * 27'(RECIP25);

  always_ff @(posedge clk) begin
    if (cmd.div_load) q_r <= qprod[RECIP_SH+7:RECIP_SH];
  end

  // result selection
  logic [DK_W-1:0]         res_dk;
  logic [LVL_W-1:0]        res_lvl, duty;
  logic                    res_fw, res_rv, res_last, later;
  logic signed [VAL_W-1:0] res_sv;

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (qual[i] && CH_W'(i) > ch_r) later = 1'b1;
    end
  end

  assign duty = duty_sat_r ? DUTY_MAX : LVL_W'(q_r);

  always_comb begin
    res_dk   = DK_READ;
    res_lvl  = '0;
    res_fw   = 1'b0;
    res_rv   = 1'b0;
    res_sv   = '0;
    res_last = 1'b1;
    unique case (cmd.emit_sel)
      EM_APPLY: begin
        case (kind)
          KIND_DIR: begin
            res_dk = DK_DUTY;
            if (duty >= LVL_W'(thresh_r)) begin
              res_lvl = duty;
              res_fw  = (vi_r > 16'sd0);
              res_rv  = !(vi_r > 16'sd0);
            end
          end
          KIND_SERVO: begin
            res_dk  = DK_ANGLE;
            res_lvl = ang_lo_r ? '0 : (ang_hi_r ? ANGLE_MAX : LVL_W'(q_r));
          end
          KIND_ESC: begin
            res_dk = DK_PULSE;
            if (vi_r < 16'sd0)        res_lvl = PULSE_MIN;
            else if (vi_r > 16'sd1000) res_lvl = PULSE_MIN + PULSE_SPAN;
            else                      res_lvl = LVL_W'(vi_r) + PULSE_MIN;
          end
          default: begin
            res_dk  = DK_DUTY;
            res_lvl = duty;
          end
        endcase
      end
      EM_STOP: begin
        res_last = !later;
        case (kind)
          KIND_SERVO: begin
            res_dk  = DK_ANGLE;
            res_lvl = ANGLE_STOP;
          end
          KIND_ESC: begin
            res_dk  = DK_PULSE;
            res_lvl = PULSE_MIN;
          end
          default: res_dk = DK_DUTY;
        endcase
      end
      EM_READ: begin
        res_sv = (32'(ch_r) < CHANNELS) ? store_r[ch_r[IDX_W-1:0]] : '0;
      end
      default: ;
    endcase
  end

  // output register
  logic                    out_valid_r;
  logic [CH_W-1:0]         o_ch_r;
  logic [DK_W-1:0]         o_dk_r;
  logic [LVL_W-1:0]        o_lvl_r;
  logic                    o_fw_r, o_rv_r, o_last_r;
  logic signed [VAL_W-1:0] o_sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_ch_r   <= ch_r;
      o_dk_r   <= res_dk;
      o_lvl_r  <= res_lvl;
      o_fw_r   <= res_fw;
      o_rv_r   <= res_rv;
      o_sv_r   <= res_sv;
      o_last_r <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_channel  = o_ch_r;
  assign out_ch.drive_kind   = o_dk_r;
  assign out_ch.drive_level  = o_lvl_r;
  assign out_ch.dir_forward  = o_fw_r;
  assign out_ch.dir_reverse  = o_rv_r;
  assign out_ch.stored_value = o_sv_r;
  assign out_ch.last         = o_last_r;

  // status
  assign stat.in_valid    = in_ch.valid;
  assign stat.opcode      = in_ch.opcode;
  assign stat.set_applies = in_store && (armed_r || !arm_req_r)
                            && (chan_kind(kinds_r, in_ch.channel) != KIND_OFF);
  assign stat.slot_free   = !out_valid_r || out_ch.ready;
  assign stat.scan_hit    = qual[ch_r[IDX_W-1:0]];
  assign stat.scan_final  = (ch_r == LAST_CH);

endmodule

// ===== design/motor_output_channel_mapper.sv =====
// ----------------------------------------------------------------------------
// motor_output_channel_mapper: per-channel command to actuator drive mapping
// Controller and datapath joined by a command/status bundle.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. A set that drives an output goes from
// acceptance through constant multiply, reciprocal divide-by-25 stage and
// output load; a set that only stores, arm and ignored opcodes end at
// acceptance; a read goes straight to the output load. Stop-all and disarm
// walk the channels one per cycle while no hit waits on the result side. The
// output register holds a finished result while the next command is taken.
// Configuration writes are taken every cycle and must be made while idle.
module motor_output_channel_mapper
  import mocm_pkg::*;
#(
  parameter int CHANNELS = MOCM_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  mocm_in_if.sink    in_ch,
  mocm_out_if.source out_ch,
  mocm_cfg_if.sink   cfg_ch
);

  mocm_cmd_t  cmd;
  mocm_stat_t stat;

  mocm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  mocm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: motor output channel mapper testbench
// Drives command beats and register writes, predicts every drive result from
// a behavioural copy of the mapper, and checks each result beat in order.
// Directed opening, then random phases over several register settings.
// ----------------------------------------------------------------------------
module tb
  import mocm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [DK_W-1:0]         kind;
    logic [LVL_W-1:0]        level;
    logic                    fwd;
    logic                    rev;
    logic signed [VAL_W-1:0] stored;
    logic                    last;
  } drive_t;

  logic clk;
  logic rst_n;

  mocm_in_if  in_ch ();
  mocm_out_if out_ch ();
  mocm_cfg_if cfg_ch ();

  motor_output_channel_mapper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the mapper's registers and state
  logic [CDATA_W-1:0]      kinds_cfg = '0;
  logic [7:0]              enable_cfg = '0;
  logic [7:0]              invert_cfg = '0;
  logic [7:0]              thresh_cfg = THRESH_RESET;
  logic                    arm_req_cfg = 1'b1;
  logic                    is_armed = 1'b0;
  logic signed [VAL_W-1:0] cmd_store [MOCM_CHANNELS];

  cmd_t   cmd_q [$];
  drive_t drive_q [$];
  cmd_t   drv_cmd;
  drive_t got;
  drive_t exp_drive;

  int  queued_n = 0;
  int  taken_n = 0;
  int  errors = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  logic in_fire = 1'b0;
  logic idle_on = 1'b1;
  logic pressure_go = 1'b0;
  logic out_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [KIND_W-1:0] kind_of(int ch);
    logic [KIND_W-1:0] k;
    k = kinds_cfg[3*ch +: KIND_W];
    if (k > KIND_ESC) k = KIND_OFF;
    return k;
  endfunction

  function automatic drive_t mk_drive(int ch, logic [DK_W-1:0] dk, int lvl,
                                      logic fw, logic rv, int sv, logic lst);
    drive_t d;
    d.channel = CH_W'(ch);
    d.kind    = dk;
    d.level   = LVL_W'(lvl);
    d.fwd     = fw;
    d.rev     = rv;
    d.stored  = VAL_W'(sv);
    d.last    = lst;
    return d;
  endfunction

  // stop levels for every enabled, driven channel; stored commands cleared
  function automatic void predict_stop();
    drive_t stops [MOCM_CHANNELS];
    int n;
    n = 0;
    for (int ch = 0; ch < MOCM_CHANNELS; ch++) begin
      cmd_store[ch] = '0;
      if (enable_cfg[ch]) begin
        case (kind_of(ch))
          KIND_MOTOR, KIND_DIR: begin
            stops[n] = mk_drive(ch, DK_DUTY, 0, 1'b0, 1'b0, 0, 1'b0);
            n++;
          end
          KIND_SERVO: begin
            stops[n] = mk_drive(ch, DK_ANGLE, ANGLE_STOP, 1'b0, 1'b0, 0, 1'b0);
            n++;
          end
          KIND_ESC: begin
            stops[n] = mk_drive(ch, DK_PULSE, PULSE_MIN, 1'b0, 1'b0, 0, 1'b0);
            n++;
          end
          default: ;
        endcase
      end
    end
    for (int i = 0; i < n; i++) begin
      stops[i].last = (i == n - 1);
      drive_q.push_back(stops[i]);
    end
  endfunction

  function automatic void predict_drive(cmd_t c);
    int ch, v, mag, duty, ang, pulse;
    ch = c.channel;
    case (c.opcode)
      OP_SET: begin
        if (enable_cfg[ch]) begin
          cmd_store[ch] = c.value;
          if (is_armed || !arm_req_cfg) begin
            v = $signed(c.value);
            if (invert_cfg[ch]) v = (v == -32768) ? 32767 : -v;
            mag = (v < 0) ? -v : v;
            duty = mag * 255 / 1000;
            if (duty > 255) duty = 255;
            case (kind_of(ch))
              KIND_MOTOR:
                drive_q.push_back(mk_drive(ch, DK_DUTY, duty, 1'b0, 1'b0, 0, 1'b1));
              KIND_DIR: begin
                if (duty < int'(thresh_cfg))
                  drive_q.push_back(mk_drive(ch, DK_DUTY, 0, 1'b0, 1'b0, 0, 1'b1));
                else if (v > 0)
                  drive_q.push_back(mk_drive(ch, DK_DUTY, duty, 1'b1, 1'b0, 0, 1'b1));
                else
                  drive_q.push_back(mk_drive(ch, DK_DUTY, duty, 1'b0, 1'b1, 0, 1'b1));
              end
              KIND_SERVO: begin
                ang = (v + 1000) * 180 / 2000;
                if (ang < 0) ang = 0;
                if (ang > 180) ang = 180;
                drive_q.push_back(mk_drive(ch, DK_ANGLE, ang, 1'b0, 1'b0, 0, 1'b1));
              end
              KIND_ESC: begin
                pulse = (v < 0) ? 0 : ((v > 1000) ? 1000 : v);
                drive_q.push_back(mk_drive(ch, DK_PULSE, pulse + 1000, 1'b0, 1'b0, 0,
                                           1'b1));
              end
              default: ;
            endcase
          end
        end
      end
      OP_ARM:    is_armed = 1'b1;
      OP_DISARM: begin
        is_armed = 1'b0;
        predict_stop();
      end
      OP_STOP:   predict_stop();
      OP_READ:
        drive_q.push_back(mk_drive(ch, DK_READ, 0, 1'b0, 1'b0, $signed(cmd_store[ch]),
                                   1'b1));
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_KINDS:   kinds_cfg = cfg_ch.data;
          CFG_ENABLE:  enable_cfg = cfg_ch.data[7:0];
          CFG_INVERT:  invert_cfg = cfg_ch.data[7:0];
          CFG_THRESH:  thresh_cfg = cfg_ch.data[7:0];
          CFG_ARM_REQ: arm_req_cfg = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        taken_n++;
        predict_drive('{in_ch.opcode, in_ch.channel, in_ch.command_value});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_channel, out_ch.drive_kind, out_ch.drive_level,
                out_ch.dir_forward, out_ch.dir_reverse, out_ch.stored_value,
                out_ch.last};
        if (drive_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none got ch %0d kind %0d level %0d",
                   $time, got.channel, got.kind, got.level);
        end else begin
          exp_drive = drive_q.pop_front();
          check_field("out_channel", exp_drive.channel, got.channel);
          check_field("drive_kind", exp_drive.kind, got.kind);
          check_field("drive_level", exp_drive.level, got.level);
          check_field("dir_forward", exp_drive.fwd, got.fwd);
          check_field("dir_reverse", exp_drive.rev, got.rev);
          check_field("stored_value", exp_drive.stored, got.stored);
          check_field("last", exp_drive.last, got.last);
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        drv_cmd = cmd_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= drv_cmd.opcode;
        in_ch.channel       <= drv_cmd.channel;
        in_ch.command_value <= drv_cmd.value;
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_hold) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 10);
    end
  end

  // long result-side hold so the mapper backs up and stalls its command input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (80) @(posedge clk);
    out_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_cmd(logic [OP_W-1:0] op, int ch, int val);
    cmd_q.push_back('{op, CH_W'(ch), VAL_W'(val)});
    queued_n++;
  endtask

  task automatic write_regs(logic [CDATA_W-1:0] kinds, logic [7:0] en, logic [7:0] inv,
                            logic [7:0] thr, logic arm_req);
    logic [CDATA_W-1:0] vals [5];
    logic [CIDX_W-1:0]  idx [5];
    vals = '{kinds, CDATA_W'(en), CDATA_W'(inv), CDATA_W'(thr), CDATA_W'(arm_req)};
    idx  = '{CFG_KINDS, CFG_ENABLE, CFG_INVERT, CFG_THRESH, CFG_ARM_REQ};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // all beats taken, all results in, then room for result-less work to finish
  task automatic settle();
    while (taken_n != queued_n || drive_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 65535) - 32768;
    if (pick == 1) begin
      case ($urandom_range(0, 6))
        0: return -32768;
        1: return 32767;
        2: return -1001;
        3: return 1001;
        4: return -1;
        5: return 1;
        default: return 0;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  function automatic logic [CDATA_W-1:0] rand_kinds();
    logic [CDATA_W-1:0] k;
    for (int ch = 0; ch < MOCM_CHANNELS; ch++)
      k[3*ch +: KIND_W] = ($urandom_range(0, 9) < 8) ? KIND_W'($urandom_range(1, 4))
                                                     : KIND_W'($urandom_range(0, 7));
    return k;
  endfunction

  task automatic push_random(int n);
    int r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      op = OP_SET;
      else if (r < 70) op = OP_READ;
      else if (r < 78) op = OP_ARM;
      else if (r < 84) op = OP_DISARM;
      else if (r < 92) op = OP_STOP;
      else             op = OP_W'($urandom_range(5, 7));
      push_cmd(op, $urandom_range(0, 7), rand_value());
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_SET;
    in_ch.channel       = '0;
    in_ch.command_value = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_KINDS;
    cfg_ch.data         = '0;
    for (int i = 0; i < MOCM_CHANNELS; i++) cmd_store[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // out of reset: nothing enabled, all kinds off
    push_cmd(OP_READ, 5, 0);
    push_cmd(OP_SET, 2, 700);
    push_cmd(OP_STOP, 0, 0);
    push_cmd(OP_ARM, 0, 0);
    push_cmd(OP_W'(6), 3, -5);
    push_cmd(OP_DISARM, 0, 0);
    settle();

    // ch0 motor, ch1 direction, ch2 servo, ch3 esc, ch4 off, ch5/ch7 unused
    // codes, ch6 inverted motor
    write_regs({KIND_W'(7), KIND_MOTOR, KIND_W'(5), KIND_OFF, KIND_ESC, KIND_SERVO,
                KIND_DIR, KIND_MOTOR}, 8'hFF, 8'h40, THRESH_RESET, 1'b1);
    push_cmd(OP_SET, 0, 1000);     // disarmed: stored only
    push_cmd(OP_READ, 0, 0);
    push_cmd(OP_ARM, 0, 0);
    push_cmd(OP_SET, 0, -32768);
    push_cmd(OP_SET, 0, 32767);
    push_cmd(OP_SET, 1, 20);       // below threshold: brake
    push_cmd(OP_SET, 1, 1000);
    push_cmd(OP_SET, 1, -1000);
    push_cmd(OP_SET, 2, -1000);
    push_cmd(OP_SET, 2, 32767);
    push_cmd(OP_SET, 3, -500);
    push_cmd(OP_SET, 3, 32767);
    push_cmd(OP_SET, 4, 1);
    push_cmd(OP_SET, 6, -32768);   // inversion saturates
    push_cmd(OP_READ, 6, 0);
    push_cmd(OP_STOP, 0, 0);
    push_cmd(OP_SET, 7, 5);
    push_cmd(OP_DISARM, 0, 0);
    push_cmd(OP_SET, 3, 600);
    push_cmd(OP_READ, 3, 0);
    settle();

    write_regs(rand_kinds(), 8'($urandom_range(0, 255)), 8'hFF, 8'hFF, 1'b0);
    pressure_go = 1'b1;
    push_random(35);
    settle();

    write_regs(rand_kinds(), 8'hFF, 8'h00, 8'h00, 1'b1);
    push_random(35);
    settle();

    write_regs({CDATA_W{1'b1}}, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b0);
    push_random(15);
    settle();

    write_regs(rand_kinds(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_random(30);
    settle();

    idle_on = 1'b0;
    write_regs(rand_kinds(), 8'hFF, 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 40)), 1'b0);
    push_random(30);
    settle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mocm_pkg.sv
design/mocm_in_if.sv
design/mocm_out_if.sv
design/mocm_cfg_if.sv
design/mocm_ctrl.sv
design/mocm_dp.sv
design/motor_output_channel_mapper.sv
verif/tb.sv
